// ===== sv/bmsc_pkg.sv =====
// Shared constants, item codes and memory control type for the bounded
// multiset substring counter. No dependencies.
package bmsc_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int MAX_TEMPLATE_DEF  = 1024;

  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int TOTAL_W  = 63;
  localparam int LEN_W    = 11;

  localparam logic [KIND_W-1:0] KIND_TEMPLATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } bmsc_mem_ctl_t;

endpackage

// ===== sv/bounded_multiset_substring_counter.sv =====
// Top level of the bounded multiset substring counter: sequencer, window
// registers and saturating total. Uses bmsc_pkg, bmsc_count_mem, bmsc_ring_mem.
//
// Template letters raise per-letter allowances; each text letter gives one
// result with the saturating running total and the current window length.
// A template letter is a count read and a write-back (neither when ignored), a
// clear needs no further state. A text letter loads its count, checks the
// window and finishes, with a ring read, count read and count write-back on the
// single-port count memory for every letter that leaves the window; each letter
// leaves at most once. A letter outside the alphabet pops every letter in the
// window in this way.
// The result sits in an output register, so a new item is taken while it
// waits; a text letter holds in its last cycle until that register is free.
module bounded_multiset_substring_counter
  import bmsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_TEMPLATE  = MAX_TEMPLATE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [LETTER_W-1:0] letter,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [TOTAL_W-1:0]  total,
  output logic [LEN_W-1:0]    window_length
);

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int RW = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
  localparam int SW = $clog2(MAX_TEMPLATE + 1);
  localparam int PW = SW + 1;
  localparam int DW = 2 * SW;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_TPL_WR   = 7'b0000010,
    S_TXT_LOAD = 7'b0000100,
    S_CHECK    = 7'b0001000,
    S_POP_CNT  = 7'b0010000,
    S_POP_WR   = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t              state;
  logic [RW-1:0]       start;
  logic [SW-1:0]       size;
  logic [SW-1:0]       template_total;
  logic [TOTAL_W-1:0]  running_total;
  logic [LETTER_W-1:0] cur_letter;
  logic [LETTER_W-1:0] pop_letter;
  logic [SW-1:0]       cur_allow;
  logic [SW-1:0]       cur_wc;
  logic                flush;

  bmsc_mem_ctl_t       cnt_ctl;
  logic [AW-1:0]       cnt_addr;
  logic [DW-1:0]       cnt_wdata;
  logic [DW-1:0]       cnt_rdata;
  logic [SW-1:0]       rd_allow;
  logic [SW-1:0]       rd_wc;

  logic                ring_wr;
  logic                ring_rd;
  logic [RW-1:0]       push_pos;
  logic [LETTER_W-1:0] ring_rdata;

  logic                item_accept;
  logic                in_alpha;
  logic                tpl_ok;
  logic                do_pop;
  logic                do_push;
  logic                out_free;
  logic [SW-1:0]       start_ext;
  logic [SW-1:0]       start_plus;
  logic [RW-1:0]       start_inc;
  logic [PW-1:0]       pos_sum;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_next;

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign in_alpha    = (32'(letter) < ALPHABET_SIZE);
  assign tpl_ok      = in_alpha && (32'(template_total) < MAX_TEMPLATE);
  assign out_free    = !result_valid || !result_stall;

  assign rd_allow = cnt_rdata[DW-1:SW];
  assign rd_wc    = cnt_rdata[SW-1:0];

  assign do_pop  = (state == S_CHECK) && (size != '0) && (flush || (cur_wc >= cur_allow));
  assign do_push = (state == S_CHECK) && !do_pop && !flush && (cur_wc < cur_allow) &&
                   (32'(size) < MAX_TEMPLATE);

  assign start_ext  = SW'(start);
  assign start_plus = start_ext + SW'(1);
  assign start_inc  = (start_plus == SW'(MAX_TEMPLATE)) ? '0 : RW'(start_plus);

  assign pos_sum  = PW'(start) + PW'(size);
  assign push_pos = (pos_sum >= PW'(MAX_TEMPLATE)) ? RW'(pos_sum - PW'(MAX_TEMPLATE))
                                                   : RW'(pos_sum);

  assign total_sum  = {1'b0, running_total} + (TOTAL_W + 1)'(size);
  assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  always_comb begin
    cnt_ctl   = '0;
    cnt_addr  = AW'(cur_letter);
    cnt_wdata = {cur_allow, cur_wc + SW'(1)};
    ring_wr   = 1'b0;
    ring_rd   = 1'b0;
    case (state)
      S_IDLE: begin
        if (item_accept) begin
          cnt_addr = AW'(letter);
          if ((kind == KIND_TEMPLATE && tpl_ok) || (kind == KIND_TEXT && in_alpha)) begin
            cnt_ctl.rd = 1'b1;
          end
          if (kind == KIND_CLEAR) begin
            cnt_ctl.clr = 1'b1;
          end
        end
      end
      S_TPL_WR: begin
        cnt_ctl.wr = 1'b1;
        cnt_wdata  = {rd_allow + SW'(1), rd_wc};
      end
      S_CHECK: begin
        cnt_ctl.wr = do_push;
        ring_wr    = do_push;
        ring_rd    = do_pop;
      end
      S_POP_CNT: begin
        cnt_ctl.rd = 1'b1;
        cnt_addr   = AW'(ring_rdata);
      end
      S_POP_WR: begin
        cnt_addr   = AW'(pop_letter);
        cnt_ctl.wr = (rd_wc != '0);
        cnt_wdata  = {rd_allow, rd_wc - SW'(1)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      start          <= '0;
      size           <= '0;
      template_total <= '0;
      running_total  <= '0;
      flush          <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_accept) begin
            cur_letter <= letter;
            case (kind)
              KIND_TEMPLATE: begin
                if (tpl_ok) begin
                  state <= S_TPL_WR;
                end
              end
              KIND_TEXT: begin
                flush <= !in_alpha;
                state <= in_alpha ? S_TXT_LOAD : S_CHECK;
              end
              KIND_CLEAR: begin
                start          <= '0;
                size           <= '0;
                template_total <= '0;
                running_total  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_TPL_WR: begin
          template_total <= template_total + SW'(1);
          state          <= S_IDLE;
        end
        S_TXT_LOAD: begin
          cur_allow <= rd_allow;
          cur_wc    <= rd_wc;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (do_pop) begin
            start <= start_inc;
            size  <= size - SW'(1);
            state <= S_POP_CNT;
          end else begin
            if (do_push) begin
              size   <= size + SW'(1);
              cur_wc <= cur_wc + SW'(1);
            end
            state <= S_FINISH;
          end
        end
        S_POP_CNT: begin
          pop_letter <= ring_rdata;
          state      <= S_POP_WR;
        end
        S_POP_WR: begin
          if (!flush && pop_letter == cur_letter && cur_wc != '0) begin
            cur_wc <= cur_wc - SW'(1);
          end
          state <= S_CHECK;
        end
        S_FINISH: begin
          if (out_free) begin
            running_total <= total_next;
            total         <= total_next;
            window_length <= LEN_W'(size);
            result_valid  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bmsc_count_mem #(
    .DEPTH (ALPHABET_SIZE),
    .AW    (AW),
    .DW    (DW)
  ) u_count_mem (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cnt_ctl),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  bmsc_ring_mem #(
    .DEPTH (MAX_TEMPLATE),
    .AW    (RW)
  ) u_ring_mem (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (push_pos),
    .wr_data (cur_letter),
    .rd_en   (ring_rd),
    .rd_addr (start),
    .rd_data (ring_rdata)
  );

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    item_accept && kind == KIND_CLEAR |=> size == '0 && running_total == '0)
    else $error("window or total not emptied by clear");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && !flush |-> cur_wc <= cur_allow)
    else $error("window count above allowance");

  a_total_monotone: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$past(item_accept && kind == KIND_CLEAR) |->
      running_total >= $past(running_total))
    else $error("running total decreased without clear");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    32'(size) <= MAX_TEMPLATE && 32'(template_total) <= MAX_TEMPLATE)
    else $error("window or template beyond ring depth");

endmodule

// ===== sv/bmsc_count_mem.sv =====
// Per-letter count memory: allowance and window count packed in one word.
// Valid bits make unwritten or cleared entries read as zero. Uses bmsc_pkg.
module bmsc_count_mem
  import bmsc_pkg::*;
#(
  parameter int DEPTH = ALPHABET_SIZE_DEF,
  parameter int AW    = $clog2(ALPHABET_SIZE_DEF),
  parameter int DW    = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  bmsc_mem_ctl_t ctl,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (ctl.rd) begin
      rd_valid <= valid[addr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

// ===== sv/bmsc_ring_mem.sv =====
// Ring buffer of window letters, one write and one registered read a cycle.
// Uses bmsc_pkg for the letter width.
module bmsc_ring_mem
  import bmsc_pkg::*;
#(
  parameter int DEPTH = MAX_TEMPLATE_DEF,
  parameter int AW    = $clog2(MAX_TEMPLATE_DEF)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [LETTER_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [LETTER_W-1:0] rd_data
);

  logic [LETTER_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
